[rtl/vsmfp_pkg.sv]
// types and constants for the varint status message frame parser
// used by varint_status_message_frame_parser_unit; no dependencies
`default_nettype none

package vsmfp_pkg;

   localparam int BufferBytes = 4096;
   localparam int PosW        = $clog2(BufferBytes + 1);
   localparam int TypeW       = 62;
   localparam int KeepW       = 12;
   localparam int MsgLenW     = 32;
   localparam int PadLenW     = 16;
   localparam int FieldCntW   = 4;
   localparam int ConsumedW   = 13;
   localparam int CsrDataW    = TypeW;
   localparam int CsrIndexW   = 1;

   localparam logic [KeepW-1:0] KeepLimitReset = KeepW'(127);
   localparam logic [5:0]       TypeFirstMask  = 6'h3F;
   localparam int               TypePrefixLsb  = 6;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FRAME_TYPE = 1'b0,
      CSR_KEEP_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_TYPE_FIRST = 4'd0,
      PH_TYPE_REST  = 4'd1,
      PH_STATUS     = 4'd2,
      PH_LENGTH     = 4'd3,
      PH_MESSAGE    = 4'd4,
      PH_AFTER_MSG  = 4'd5,
      PH_PAD_LO     = 4'd6,
      PH_PADDING    = 4'd7,
      PH_DONE       = 4'd8,
      PH_ERROR      = 4'd9
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]           message_byte;
      logic                 message_byte_valid;
      logic                 trailing_byte;
      logic                 frame_done;
      logic                 frame_error;
      logic [7:0]           status_code;
      logic [ConsumedW-1:0] consumed_count;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/varint_status_message_frame_parser_unit.sv]
// frame parser: varint type, status, length-prefixed message, optional padding
// depends on vsmfp_pkg
`default_nettype none

// Usage
// req channel: one buffer byte per request, final_byte on the last byte of
//   the buffer; req_payload is taken when req_valid is high and req_stall low.
// rsp channel: exactly one response per request, in order, taken when
//   rsp_valid is high and rsp_stall low. Kept message bytes, trailing flags,
//   and on the final byte either frame_done (with status and byte count) or
//   frame_error.
// csr port: write csr_write_data to register csr_index while csr_write_enable
//   is high; index 0 is the expected frame type, index 1 the keep limit.
//   Write only while no request is in flight.
// The parse step is combinational from the request to the response register,
//   or to the skid stage while that register is held; throughput is one byte
//   per cycle while req_stall is low.
// A one-entry skid stage behind the response register keeps requests flowing
//   while a response waits; req_stall rises only when both hold a response.
// Synchronous reset clears the parser to the first type byte, empties the
//   response stages and loads register reset values (type 0, keep limit 127).
module varint_status_message_frame_parser_unit
   import vsmfp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_payload,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_write_data
);

   logic [TypeW-1:0]     exp_type_ff, exp_type_in;
   logic [KeepW-1:0]     keep_limit_ff, keep_limit_in;

   phase_type            phase_ff, phase_in, phase_cur, phase_step;
   logic [FieldCntW-1:0] field_left_ff, field_left_in, field_left_step, field_dec;
   logic [TypeW-1:0]     type_acc_ff, type_acc_in, type_acc_step;
   logic [7:0]           status_ff, status_in, status_step;
   logic [MsgLenW-1:0]   msg_left_ff, msg_left_in, msg_left_step, msg_dec;
   logic [KeepW-1:0]     msg_index_ff, msg_index_in, msg_index_step;
   logic [PadLenW-1:0]   pad_left_ff, pad_left_in, pad_left_step, pad_dec;
   logic [PosW-1:0]      pos_ff, pos_in, pos_next;
   logic [PosW-1:0]      frame_end_ff, frame_end_in, frame_end_step;

   logic                 overflow, type_match, keep_byte, is_final, accept;
   logic [7:0]           data;
   logic [1:0]           prefix;
   rsp_type              result;

   rsp_type              out_ff, out_in, skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign data     = req_payload.data_byte;
   assign is_final = req_payload.final_byte;
   assign prefix   = data[7:TypePrefixLsb];

   assign req_stall   = skid_valid_ff;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // configuration
   always_comb begin
      exp_type_in   = exp_type_ff;
      keep_limit_in = keep_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_TYPE: exp_type_in   = csr_write_data;
            CSR_KEEP_LIMIT: keep_limit_in = csr_write_data[KeepW-1:0];
            default:        exp_type_in   = exp_type_ff;
         endcase
      end
   end

   // parse datapath
   assign overflow  = pos_ff >= PosW'(BufferBytes);
   assign pos_next  = overflow ? PosW'(BufferBytes) : pos_ff + PosW'(1);
   assign phase_cur = overflow ? PH_ERROR : phase_ff;
   assign field_dec = field_left_ff - FieldCntW'(1);
   assign msg_dec   = msg_left_ff - MsgLenW'(1);
   assign pad_dec   = pad_left_ff - PadLenW'(1);
   assign keep_byte = (phase_cur == PH_MESSAGE) && (msg_index_ff < keep_limit_ff);

   always_comb begin
      field_left_step = field_left_ff;
      type_acc_step   = type_acc_ff;
      status_step     = status_ff;
      msg_left_step   = msg_left_ff;
      msg_index_step  = msg_index_ff;
      pad_left_step   = pad_left_ff;
      frame_end_step  = frame_end_ff;
      unique case (phase_cur)
         PH_TYPE_FIRST: begin
            type_acc_step = {{(TypeW-6){1'b0}}, data[5:0] & TypeFirstMask};
            unique case (prefix)
               2'd1:    field_left_step = FieldCntW'(1);
               2'd2:    field_left_step = FieldCntW'(3);
               2'd3:    field_left_step = FieldCntW'(7);
               default: field_left_step = field_left_ff;
            endcase
         end
         PH_TYPE_REST: begin
            type_acc_step   = {type_acc_ff[TypeW-9:0], data};
            field_left_step = field_dec;
         end
         PH_STATUS: begin
            status_step     = data;
            field_left_step = FieldCntW'(4);
            msg_left_step   = '0;
         end
         PH_LENGTH: begin
            msg_left_step   = {msg_left_ff[MsgLenW-9:0], data};
            field_left_step = field_dec;
            if (field_dec == '0) begin
               frame_end_step = pos_next;
            end
         end
         PH_MESSAGE: begin
            if (msg_index_ff != '1) begin
               msg_index_step = msg_index_ff + KeepW'(1);
            end
            msg_left_step = msg_dec;
            if (msg_dec == '0) begin
               frame_end_step = pos_next;
            end
         end
         PH_AFTER_MSG: begin
            if (!is_final) begin
               pad_left_step = {data, 8'h00};
            end
         end
         PH_PAD_LO: begin
            pad_left_step  = {pad_left_ff[PadLenW-1:8], data};
            frame_end_step = pos_next;
         end
         PH_PADDING: begin
            pad_left_step = pad_dec;
            if (pad_dec == '0) begin
               frame_end_step = pos_next;
            end
         end
         default: begin
            field_left_step = field_left_ff;
         end
      endcase
   end

   assign type_match = type_acc_step == exp_type_ff;

   // next state
   always_comb begin
      unique case (phase_cur)
         PH_TYPE_FIRST: begin
            if (prefix == 2'd0) begin
               phase_step = type_match ? PH_STATUS : PH_ERROR;
            end else begin
               phase_step = PH_TYPE_REST;
            end
         end
         PH_TYPE_REST: begin
            if (field_dec == '0) begin
               phase_step = type_match ? PH_STATUS : PH_ERROR;
            end else begin
               phase_step = PH_TYPE_REST;
            end
         end
         PH_STATUS: phase_step = PH_LENGTH;
         PH_LENGTH: begin
            if (field_dec == '0) begin
               phase_step = (msg_left_step == '0) ? PH_AFTER_MSG : PH_MESSAGE;
            end else begin
               phase_step = PH_LENGTH;
            end
         end
         PH_MESSAGE:   phase_step = (msg_dec == '0) ? PH_AFTER_MSG : PH_MESSAGE;
         PH_AFTER_MSG: phase_step = is_final ? PH_DONE : PH_PAD_LO;
         PH_PAD_LO:    phase_step = (pad_left_step == '0) ? PH_DONE : PH_PADDING;
         PH_PADDING:   phase_step = (pad_dec == '0) ? PH_DONE : PH_PADDING;
         PH_DONE:      phase_step = PH_DONE;
         default:      phase_step = PH_ERROR;
      endcase
      phase_in = is_final ? PH_TYPE_FIRST : phase_step;
   end

   // response and state commit, cleared after the final byte
   always_comb begin
      result                    = '0;
      result.message_byte_valid = keep_byte;
      result.message_byte       = keep_byte ? data : 8'h00;
      result.trailing_byte      = (phase_cur == PH_DONE) ||
                                  ((phase_cur == PH_AFTER_MSG) && is_final);
      if (is_final) begin
         if ((phase_step == PH_DONE) || (phase_step == PH_AFTER_MSG)) begin
            result.frame_done     = 1'b1;
            result.status_code    = status_step;
            result.consumed_count = ConsumedW'(frame_end_step);
         end else begin
            result.frame_error = 1'b1;
         end
      end

      if (is_final) begin
         field_left_in = '0;
         type_acc_in   = '0;
         status_in     = '0;
         msg_left_in   = '0;
         msg_index_in  = '0;
         pad_left_in   = '0;
         pos_in        = '0;
         frame_end_in  = '0;
      end else begin
         field_left_in = field_left_step;
         type_acc_in   = type_acc_step;
         status_in     = status_step;
         msg_left_in   = msg_left_step;
         msg_index_in  = msg_index_step;
         pad_left_in   = pad_left_step;
         pos_in        = pos_next;
         frame_end_in  = frame_end_step;
      end
   end

   // response register and skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_type_ff   <= '0;
         keep_limit_ff <= KeepLimitReset;
         phase_ff      <= PH_TYPE_FIRST;
         field_left_ff <= '0;
         type_acc_ff   <= '0;
         status_ff     <= '0;
         msg_left_ff   <= '0;
         msg_index_ff  <= '0;
         pad_left_ff   <= '0;
         pos_ff        <= '0;
         frame_end_ff  <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         exp_type_ff   <= exp_type_in;
         keep_limit_ff <= keep_limit_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            field_left_ff <= field_left_in;
            type_acc_ff   <= type_acc_in;
            status_ff     <= status_in;
            msg_left_ff   <= msg_left_in;
            msg_index_ff  <= msg_index_in;
            pad_left_ff   <= pad_left_in;
            pos_ff        <= pos_in;
            frame_end_ff  <= frame_end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a response while the response register is empty");

   a_done_xor_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.frame_done && out_ff.frame_error))
      else $error("response reports done and error together");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_final) |=> (phase_ff == PH_TYPE_FIRST) && (pos_ff == '0))
      else $error("parser not cleared after the final byte");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(BufferBytes))
      else $error("byte position beyond the buffer size");

   a_kept_not_trailing: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.message_byte_valid && out_ff.trailing_byte))
      else $error("byte flagged both kept and trailing");
`endif

endmodule

`default_nettype wire
